// ===== src/rtnb_pkg.sv =====
`timescale 1ns / 1ps
package rtnb_pkg;
   localparam int MAX_LEAVES = 1024;
   localparam int IDX_W      = 10;
   localparam int CNT_W      = 11;
   localparam int CODE_W     = 32;
   localparam int PFX_W      = 8;   // prefix length 0..64, -1 as all ones
   localparam int SRCH_W     = 13;  // signed leaf index for probes
   localparam int QDEPTH     = 2;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_BUILD = 1'b1;

   typedef struct packed {
      logic             opcode;
      logic [IDX_W-1:0] index;
      logic [CODE_W-1:0] code_value;
   } item_type;

   typedef struct packed {
      logic [IDX_W-1:0] node_number;
      logic [IDX_W-1:0] range_first;
      logic [IDX_W-1:0] range_last;
      logic [IDX_W-1:0] split_position;
      logic             left_is_leaf;
      logic             right_is_leaf;
      logic             bad_index;
   } result_type;

   function automatic logic [5:0] clz32(input logic [31:0] v);
      logic [5:0] n;
      logic       done;
      n = 6'd0;
      done = 1'b0;
      for (int b = 31; b >= 0; b--) begin
         if (v[b]) done = 1'b1;
         else if (!done) n = n + 6'd1;
      end
      return n;
   endfunction
endpackage

// ===== src/radix_tree_node_builder_core.sv =====
`timescale 1ns / 1ps
// channel  ports        word
// req      req_t*       tdata: opcode[0], index[10:1], code_value[42:11]
// rsp      rsp_t*       tdata: node_number, range_first, range_last, split, flags
// csr      csr_p*       leaf_count at address 0
// A build reads the node code, its two neighbours, the exponential search probes
// and two binary searches, one code at a time through the single read port of
// the code store.
// Reset is synchronous; the code store is not cleared.
// A two-word queue parts input from the builder; results wait in a register.
module radix_tree_node_builder_core import rtnb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // opcode, index, code_value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // node_number, range_first, range_last,
                                   // split_position, left_is_leaf, right_is_leaf, bad_index
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   logic [CNT_W-1:0] leaf_count_ff;
   item_type         in_item, q_item;
   logic             q_valid, q_ready;
   result_type       res;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == 2'd0) ? {21'd0, leaf_count_ff} : 32'd0;
   always_ff @(posedge clock) begin
      if (reset) leaf_count_ff <= CNT_W'(2);
      else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == 2'd0)
         leaf_count_ff <= csr_pwdata[CNT_W-1:0];
   end

   assign in_item.opcode     = req_tdata[0];
   assign in_item.index      = req_tdata[10:1];
   assign in_item.code_value = req_tdata[42:11];

   rtnb_front u_front (.clock, .reset, .in_valid(req_tvalid), .in_ready(req_tready),
      .in_item, .q_valid, .q_ready, .q_item);

   rtnb_back u_back (.clock, .reset, .leaf_count(leaf_count_ff), .q_valid, .q_ready,
      .q_item, .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_res(res));

   assign rsp_tdata = {5'd0, res.bad_index, res.right_is_leaf, res.left_is_leaf,
      res.split_position, res.range_last, res.range_first, res.node_number};
endmodule

// ===== src/rtnb_front.sv =====
`timescale 1ns / 1ps
module rtnb_front import rtnb_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   output logic     q_valid,
   input  logic     q_ready,
   output item_type q_item
);
   item_type        mem_ff [QDEPTH];
   logic            wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]      cnt_ff, cnt_in;
   logic            push, pop;

   assign in_ready = (cnt_ff != 2'(QDEPTH));
   assign push     = in_valid && in_ready;
   assign q_valid  = (cnt_ff != 2'd0);
   assign pop      = q_valid && q_ready;
   assign q_item   = mem_ff[rp_ff];

   // queue pointers
   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= in_item;
   end
endmodule

// ===== src/rtnb_back.sv =====
`timescale 1ns / 1ps
module rtnb_back import rtnb_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [CNT_W-1:0] leaf_count,
   input  logic             q_valid,
   output logic             q_ready,
   input  item_type         q_item,
   output logic             out_valid,
   input  logic             out_ready,
   output result_type       out_res
);
   localparam logic [3:0] S_IDLE = 4'd0, S_RDI = 4'd1, S_P1 = 4'd2, S_P2 = 4'd3,
                          S_EXP = 4'd4, S_B1 = 4'd5, S_DN = 4'd6, S_B2 = 4'd7,
                          S_FIN = 4'd8, S_OUT = 4'd9, S_RDW = 4'd10;

   logic [CODE_W-1:0] store [MAX_LEAVES];
   logic [CODE_W-1:0] rd_ff, ci_ff, ci_in;

   logic [3:0]        st_ff, st_in;
   logic [IDX_W-1:0]  i_ff, i_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic              neg_ff, neg_in;
   logic [PFX_W-1:0]  pa_ff, pa_in, dmin_ff, dmin_in;
   logic [CNT_W+1:0]  lmax_ff, lmax_in, t_ff, t_in, acc_ff, acc_in;
   logic [SRCH_W-1:0] probe_ff, probe_in, j_ff, j_in;
   logic [3:0]        ret_ff, ret_in;
   logic              pvalid_ff, pvalid_in;
   result_type        res_ff, res_in;
   logic              ov_ff, ov_in;

   // prefix length of stored probe against node code
   logic [CODE_W-1:0] x;
   logic [31:0]       ix;
   logic [PFX_W-1:0]  plen;
   always_comb begin
      x  = ci_ff ^ rd_ff;
      ix = {22'd0, i_ff} ^ {{(32-SRCH_W){1'b0}}, probe_ff};
      if (!pvalid_ff)   plen = '1;
      else if (x != '0) plen = PFX_W'(clz32(x));
      else              plen = PFX_W'(CODE_W) + PFX_W'(clz32(ix));
   end

   logic              sgt_dmin;
   assign sgt_dmin = $signed(plen) > $signed(dmin_ff);

   function automatic logic [SRCH_W-1:0] offs(input logic [IDX_W-1:0] b,
         input logic [CNT_W+1:0] k, input logic ng);
      logic [SRCH_W-1:0] bb, kk;
      bb = {{(SRCH_W-IDX_W){1'b0}}, b};
      kk = SRCH_W'(k);
      return ng ? bb - kk : bb + kk;
   endfunction

   // next probe address and in-range flag
   logic [SRCH_W-1:0] nx;
   logic              nx_ok;
   logic [IDX_W-1:0]  rd_addr;
   always_comb begin
      nx = '0;
      unique case (st_ff)
         S_RDI:  nx = offs(i_ff, (CNT_W+2)'(1), 1'b0);
         S_P1:   nx = offs(i_ff, (CNT_W+2)'(1), 1'b1);
         default: nx = '0;
      endcase
      nx_ok = !nx[SRCH_W-1] && (nx < {2'b0, n_ff});
   end

   logic             is_bad;
   assign is_bad = (q_item.index >= ((leaf_count > CNT_W'(MAX_LEAVES)) ?
                   CNT_W'(MAX_LEAVES - 1) : leaf_count - 1'b1)) || (leaf_count < 2);
   assign q_ready  = (st_ff == S_IDLE) && !ov_ff;
   assign out_valid = ov_ff;
   assign out_res   = res_ff;

   logic [SRCH_W-1:0] gam, lo, hi;
   always_comb begin
      st_in = st_ff; i_in = i_ff; n_in = n_ff; neg_in = neg_ff; pa_in = pa_ff;
      dmin_in = dmin_ff; lmax_in = lmax_ff; t_in = t_ff; acc_in = acc_ff;
      probe_in = probe_ff; j_in = j_ff; ret_in = ret_ff; pvalid_in = pvalid_ff;
      ci_in = ci_ff; res_in = res_ff; ov_in = ov_ff;
      gam = '0; lo = '0; hi = '0;
      if (ov_ff && out_ready) ov_in = 1'b0;
      unique case (st_ff)
         S_IDLE: if (q_valid && !ov_ff) begin
            i_in = q_item.index;
            n_in = (leaf_count > CNT_W'(MAX_LEAVES)) ? CNT_W'(MAX_LEAVES) : leaf_count;
            if (q_item.opcode == OP_BUILD) begin
               if (is_bad) begin
                  res_in = '0; res_in.node_number = q_item.index;
                  res_in.bad_index = 1'b1; ov_in = 1'b1;
               end else begin
                  st_in = S_RDI;
               end
            end
         end
         S_RDI: begin
            ci_in = rd_ff; probe_in = nx; pvalid_in = nx_ok; st_in = S_RDW; ret_in = S_P1;
         end
         S_RDW: st_in = ret_ff;
         S_P1: begin
            pa_in = plen; probe_in = nx; pvalid_in = nx_ok; st_in = S_RDW; ret_in = S_P2;
         end
         S_P2: begin
            neg_in = !($signed(pa_ff) > $signed(plen));
            // dmin is prefix with i-d: that is the probe just read if d=+1
            dmin_in = neg_in ? pa_ff : plen;
            lmax_in = (CNT_W+2)'(2);
            probe_in = offs(i_ff, (CNT_W+2)'(2), neg_in);
            pvalid_in = !probe_in[SRCH_W-1] && (probe_in < {2'b0, n_ff});
            st_in = S_RDW; ret_in = S_EXP;
         end
         S_EXP: begin
            if (lmax_ff <= (CNT_W+2)'(2*MAX_LEAVES) && sgt_dmin) begin
               lmax_in = lmax_ff << 1;
               probe_in = offs(i_ff, lmax_in, neg_ff);
               pvalid_in = !probe_in[SRCH_W-1] && (probe_in < {2'b0, n_ff});
               st_in = S_RDW; ret_in = S_EXP;
            end else begin
               acc_in = '0; t_in = lmax_ff >> 1;
               probe_in = offs(i_ff, t_in, neg_ff);
               pvalid_in = !probe_in[SRCH_W-1] && (probe_in < {2'b0, n_ff});
               st_in = S_RDW; ret_in = S_B1;
            end
         end
         S_B1: begin
            if (sgt_dmin) acc_in = acc_ff + t_ff;
            t_in = t_ff >> 1;
            if (t_in != '0) begin
               probe_in = offs(i_ff, acc_in + t_in, neg_ff);
               pvalid_in = !probe_in[SRCH_W-1] && (probe_in < {2'b0, n_ff});
               st_in = S_RDW; ret_in = S_B1;
            end else begin
               j_in = offs(i_ff, acc_in, neg_ff);
               probe_in = j_in;
               pvalid_in = !probe_in[SRCH_W-1] && (probe_in < {2'b0, n_ff});
               st_in = S_RDW; ret_in = S_DN;
            end
         end
         S_DN: begin
            dmin_in = plen; acc_in = '0; t_in = lmax_ff >> 1;
            probe_in = offs(i_ff, t_in, neg_ff);
            pvalid_in = !probe_in[SRCH_W-1] && (probe_in < {2'b0, n_ff});
            st_in = S_RDW; ret_in = S_B2;
         end
         S_B2: begin
            if (sgt_dmin) acc_in = acc_ff + t_ff;
            t_in = t_ff >> 1;
            if (t_in != '0) begin
               probe_in = offs(i_ff, acc_in + t_in, neg_ff);
               pvalid_in = !probe_in[SRCH_W-1] && (probe_in < {2'b0, n_ff});
               st_in = S_RDW; ret_in = S_B2;
            end else begin
               st_in = S_FIN;
            end
         end
         S_FIN: begin
            gam = offs(i_ff, acc_ff, neg_ff) - (neg_ff ? SRCH_W'(1) : SRCH_W'(0));
            if (gam[SRCH_W-1]) gam = '0;
            if ($signed(gam) > $signed({2'b0, n_ff} - SRCH_W'(2)))
               gam = {2'b0, n_ff} - SRCH_W'(2);
            lo = neg_ff ? j_ff : {3'b0, i_ff};
            hi = neg_ff ? {3'b0, i_ff} : j_ff;
            if (lo[SRCH_W-1]) lo = '0;
            if ($signed(hi) > $signed({2'b0, n_ff} - SRCH_W'(1)))
               hi = {2'b0, n_ff} - SRCH_W'(1);
            res_in.node_number    = i_ff;
            res_in.range_first    = lo[IDX_W-1:0];
            res_in.range_last     = hi[IDX_W-1:0];
            res_in.split_position = gam[IDX_W-1:0];
            res_in.left_is_leaf   = (lo == gam);
            res_in.right_is_leaf  = (hi == gam + SRCH_W'(1));
            res_in.bad_index      = 1'b0;
            st_in = S_OUT;
         end
         S_OUT: if (!ov_ff) begin
            ov_in = 1'b1; st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   // code store: write on load, read the probe (or node) address
   always_comb rd_addr = (st_ff == S_IDLE) ? q_item.index : probe_in[IDX_W-1:0];
   always_ff @(posedge clock) begin
      if (st_ff == S_IDLE && q_valid && !ov_ff && q_item.opcode == OP_LOAD)
         store[q_item.index] <= q_item.code_value;
      rd_ff <= store[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in; ov_ff <= ov_in;
      end
      i_ff <= i_in; n_ff <= n_in; neg_ff <= neg_in; pa_ff <= pa_in;
      dmin_ff <= dmin_in; lmax_ff <= lmax_in; t_ff <= t_in; acc_ff <= acc_in;
      probe_ff <= probe_in; j_ff <= j_in; ret_ff <= ret_in;
      pvalid_ff <= pvalid_in; ci_ff <= ci_in; res_ff <= res_in;
   end
endmodule

// ===== tb/radix_node_checker.sv =====
`timescale 1ns / 1ps
// Watches the request, response and register ports, predicts each node build
// and compares the response words against the predicted nodes in order.
module radix_node_checker import rtnb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          fail_count,
   output int          nodes_pending
);
   logic [CODE_W-1:0] code_mem [MAX_LEAVES];
   logic [CNT_W-1:0]  leaf_cnt;
   result_type        node_q[$];

   // common prefix of leaves a and b, -1 outside the tree
   function automatic int common_prefix(int a, int b, int n);
      logic [31:0] x;
      logic [31:0] ix;
      int z;
      if (b < 0 || b >= n || a < 0 || a >= n) return -1;
      x = code_mem[a] ^ code_mem[b];
      ix = a ^ b;
      if (x == 0) begin
         x = ix;
         z = 32;
      end else begin
         z = 0;
      end
      for (int k = 31; k >= 0; k--) begin
         if (x[k]) return z;
         z++;
      end
      return z;
   endfunction

   function automatic result_type build_node(int i);
      result_type r;
      int n, d, dmin, dnode, lmax, l, s, j, split, lo, hi;
      n = (leaf_cnt > MAX_LEAVES) ? MAX_LEAVES : int'(leaf_cnt);
      r = '0;
      r.node_number = IDX_W'(i);
      if (n < 2 || i >= n - 1) begin
         r.bad_index = 1'b1;
         return r;
      end
      d = (common_prefix(i, i + 1, n) - common_prefix(i, i - 1, n)) > 0 ? 1 : -1;
      dmin = common_prefix(i, i - d, n);
      // exponential search for the far end, then binary refine
      lmax = 2;
      while (lmax <= 2 * MAX_LEAVES && common_prefix(i, i + lmax * d, n) > dmin)
         lmax *= 2;
      l = 0;
      for (int t = lmax / 2; t > 0; t /= 2)
         if (common_prefix(i, i + (l + t) * d, n) > dmin) l += t;
      j = i + l * d;
      dnode = common_prefix(i, j, n);
      s = 0;
      for (int t = lmax / 2; t > 0; t /= 2)
         if (common_prefix(i, i + (s + t) * d, n) > dnode) s += t;
      split = i + s * d + (d < 0 ? d : 0);
      if (split < 0) split = 0;
      if (split > n - 2) split = n - 2;
      lo = i < j ? i : j;
      hi = i < j ? j : i;
      if (lo < 0) lo = 0;
      if (hi > n - 1) hi = n - 1;
      r.range_first = IDX_W'(lo);
      r.range_last = IDX_W'(hi);
      r.split_position = IDX_W'(split);
      r.left_is_leaf = (lo == split);
      r.right_is_leaf = (hi == split + 1);
      return r;
   endfunction

   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (reset) begin
         leaf_cnt <= 2;
         fail_count <= 0;
         node_q.delete();
      end else begin
         // register write
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == 2'd0)
            leaf_cnt <= csr_pwdata[CNT_W-1:0];
         // request word
         if (req_tvalid && req_tready) begin
            if (req_tdata[0] == OP_LOAD)
               code_mem[req_tdata[10:1]] = req_tdata[42:11];
            else
               node_q = {node_q, build_node(int'(req_tdata[10:1]))};
         end
         // response word
         if (rsp_tvalid && rsp_tready) begin
            got.node_number    = rsp_tdata[9:0];
            got.range_first    = rsp_tdata[19:10];
            got.range_last     = rsp_tdata[29:20];
            got.split_position = rsp_tdata[39:30];
            got.left_is_leaf   = rsp_tdata[40];
            got.right_is_leaf  = rsp_tdata[41];
            got.bad_index      = rsp_tdata[42];
            if (node_q.size() == 0) begin
               if (fail_count < 10) $display("ERROR: unexpected node word %h", rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               want = node_q.pop_front();
               if (got !== want || rsp_tdata[47:43] !== 5'd0) begin
                  if (fail_count < 10) begin
                     $display("ERROR: node %0d exp %0d..%0d split %0d l%0b r%0b bad%0b,",
                        want.node_number, want.range_first, want.range_last,
                        want.split_position, want.left_is_leaf, want.right_is_leaf,
                        want.bad_index);
                     $display("       got node %0d %0d..%0d split %0d l%0b r%0b bad%0b",
                        got.node_number, got.range_first, got.range_last,
                        got.split_position, got.left_is_leaf, got.right_is_leaf,
                        got.bad_index);
                  end
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      nodes_pending <= node_q.size();
   end
endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;
   import rtnb_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;     // opcode, index, code_value
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;          // node_number, range_first, range_last,
                                    // split_position, left_is_leaf, right_is_leaf, bad_index
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [1:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          fail_count;
   int          nodes_pending;
   int          quiet_cycles = 0;
   bit          no_idle = 1'b0;

   radix_tree_node_builder_core u_dut (.*);

   radix_node_checker u_chk (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // watchdog: cycles with no word moving on either channel
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 5000) begin
         $display("radix_tree_node_builder_core verification failed");
         $finish;
      end
   end

   function automatic int draw_gap();
      if (no_idle) return 0;
      return $urandom_range(0, 16);
   endfunction

   // response side stalls
   initial begin
      int gap;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = draw_gap();
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   task automatic send_word(input logic op, input int idx,
                            input logic [CODE_W-1:0] code);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {5'd0, code, IDX_W'(idx), op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // register writes only with no node outstanding
   task automatic set_leaves(input int value);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (nodes_pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= 2'd0;
      csr_pwdata <= value;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // sorted codes with runs of duplicates, or random ones
   task automatic load_codes(input int count, input bit sorted);
      logic [31:0] v;
      v = $urandom & 32'h8000_0fff;
      if (v[31]) v = $urandom_range(0, 4095);
      for (int k = 0; k < count; k++) begin
         if (sorted) begin
            send_word(OP_LOAD, k, v);
            if ($urandom_range(0, 3) != 0) v = v + $urandom_range(1, 1 << 21);
         end else begin
            send_word(OP_LOAD, k, $urandom);
         end
      end
   endtask

   initial begin
      int n;
      int nb;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // low leaves first; later trees stay within them, so builds read written codes
      load_codes(128, 1'b1);
      set_leaves(128);
      send_word(OP_BUILD, 0, '0);
      send_word(OP_BUILD, 1, '0);
      send_word(OP_BUILD, 63, '0);
      send_word(OP_BUILD, 126, '0);
      send_word(OP_BUILD, 127, '0);
      send_word(OP_LOAD, 127, 32'hffff_ffff);
      send_word(OP_BUILD, 125, '0);
      send_word(OP_BUILD, 126, '0);
      set_leaves(2);
      send_word(OP_BUILD, 0, '0);
      send_word(OP_BUILD, 1, '0);
      set_leaves(0);
      send_word(OP_BUILD, 0, '0);
      set_leaves(1);
      send_word(OP_BUILD, 0, '0);
      send_word(OP_BUILD, 1023, '0);
      set_leaves(2047);
      send_word(OP_BUILD, 1023, '0);

      // random phases: fresh codes for trees of up to 64 leaves, then mostly builds inside the tree
      for (int ph = 0; ph < 7; ph++) begin
         no_idle = (ph % 4 == 3);
         n = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 128) : $urandom_range(2, 40);
         set_leaves(n);
         if (n <= 64) load_codes(n, $urandom_range(0, 4) != 0);
         nb = 20;
         for (int k = 0; k < nb; k++) begin
            if ($urandom_range(0, 9) == 0)
               send_word(OP_LOAD, $urandom_range(0, 1023), $urandom);
            else if ($urandom_range(0, 7) == 0)
               send_word(OP_BUILD, $urandom_range(0, 1023), $urandom);
            else
               send_word(OP_BUILD, $urandom_range(0, (n > 1 ? n : 2) - 1), $urandom);
         end
      end
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (nodes_pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0) begin
         $display("radix_tree_node_builder_core verification clean");
      end else begin
         $display("radix_tree_node_builder_core verification failed");
      end
      $finish;
   end
endmodule
